@@ design/rdwe_pkg.sv @@
`default_nettype none

package rdwe_pkg;

  localparam int unsigned OpcodeW    = 2;
  localparam int unsigned DataW      = 32;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned GapW       = 8;
  localparam int unsigned OnW        = 10;
  localparam int unsigned BitOnW     = 8;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 10;

  localparam int unsigned FrameW     = OpcodeW + 1 + DataW + AddrW;
  localparam int unsigned SymIdxW    = $clog2(FrameW + 1);

  localparam int unsigned DefaultQueueDepth = 2;

  localparam logic [GapW-1:0]   StartGapReset   = 8'd25;
  localparam logic [GapW-1:0]   BitGapReset     = 8'd20;
  localparam logic [BitOnW-1:0] ZeroOnReset     = 8'd24;
  localparam logic [BitOnW-1:0] OneOnReset      = 8'd56;
  localparam logic [OnW-1:0]    ProgramOnReset  = 10'd700;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_GAP  = 3'd0,
    REG_BIT_GAP    = 3'd1,
    REG_ZERO_ON    = 3'd2,
    REG_ONE_ON     = 3'd3,
    REG_PROGRAM_ON = 3'd4
  } reg_idx_e;

  typedef logic [FrameW-1:0] frame_t;

  typedef struct packed {
    logic [GapW-1:0]   start_gap;
    logic [GapW-1:0]   bit_gap;
    logic [BitOnW-1:0] zero_on;
    logic [BitOnW-1:0] one_on;
    logic [OnW-1:0]    program_on;
  } cfg_t;

endpackage

`default_nettype wire

@@ design/rdwe_if.sv @@
`default_nettype none

interface rdwe_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [rdwe_pkg::OpcodeW-1:0]  opcode;
  logic                          lock_bit;
  logic [rdwe_pkg::DataW-1:0]    block_data;
  logic [rdwe_pkg::AddrW-1:0]    block_address;

  modport source (output valid, opcode, lock_bit, block_data, block_address, input ready);
  modport sink   (input valid, opcode, lock_bit, block_data, block_address, output ready);
endinterface

interface rdwe_sym_if;
  logic                       valid;
  logic                       ready;
  logic [rdwe_pkg::GapW-1:0]  off_cycles;
  logic [rdwe_pkg::OnW-1:0]   on_cycles;
  logic                       symbol_bit;
  logic                       program_wait;
  logic                       last;

  modport source (output valid, off_cycles, on_cycles, symbol_bit, program_wait, last,
                  input ready);
  modport sink   (input valid, off_cycles, on_cycles, symbol_bit, program_wait, last,
                  output ready);
endinterface

interface rdwe_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rdwe_pkg::CfgIdxW-1:0]   idx;
  logic [rdwe_pkg::CfgDataW-1:0]  wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

`default_nettype wire

@@ design/rdwe_cfg.sv @@
`default_nettype none

module rdwe_cfg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  rdwe_cfg_if.sink        cfg_i,
  output rdwe_pkg::cfg_t  cfg_o
);

  rdwe_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.idx)
        rdwe_pkg::REG_START_GAP:  cfg_d.start_gap  = cfg_i.wdata[rdwe_pkg::GapW-1:0];
        rdwe_pkg::REG_BIT_GAP:    cfg_d.bit_gap    = cfg_i.wdata[rdwe_pkg::GapW-1:0];
        rdwe_pkg::REG_ZERO_ON:    cfg_d.zero_on    = cfg_i.wdata[rdwe_pkg::BitOnW-1:0];
        rdwe_pkg::REG_ONE_ON:     cfg_d.one_on     = cfg_i.wdata[rdwe_pkg::BitOnW-1:0];
        rdwe_pkg::REG_PROGRAM_ON: cfg_d.program_on = cfg_i.wdata[rdwe_pkg::OnW-1:0];
        default:                  cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_gap  <= rdwe_pkg::StartGapReset;
      cfg_q.bit_gap    <= rdwe_pkg::BitGapReset;
      cfg_q.zero_on    <= rdwe_pkg::ZeroOnReset;
      cfg_q.one_on     <= rdwe_pkg::OneOnReset;
      cfg_q.program_on <= rdwe_pkg::ProgramOnReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

@@ design/rdwe_front.sv @@
`default_nettype none

module rdwe_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  rdwe_cmd_if.sink          cmd_i,
  output logic              push_valid_o,
  output rdwe_pkg::frame_t  push_frame_o,
  input  wire logic         push_ready_i
);

  logic             valid_d, valid_q;
  rdwe_pkg::frame_t frame_d, frame_q;
  logic             accept;
  logic             push;

  assign push         = valid_q && push_ready_i;
  assign cmd_i.ready  = !valid_q || push_ready_i;
  assign accept       = cmd_i.valid && cmd_i.ready;
  assign push_valid_o = valid_q;
  assign push_frame_o = frame_q;

  // The command is packed into the order in which its bits go on air.
  always_comb begin
    valid_d = valid_q;
    frame_d = frame_q;
    if (accept) begin
      valid_d = 1'b1;
      frame_d = {cmd_i.opcode, cmd_i.lock_bit, cmd_i.block_data, cmd_i.block_address};
    end else if (push) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

endmodule

`default_nettype wire

@@ design/rdwe_fifo.sv @@
`default_nettype none

module rdwe_fifo #(
  parameter int unsigned Depth = rdwe_pkg::DefaultQueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  input  wire rdwe_pkg::frame_t  push_frame_i,
  output logic                   push_ready_o,
  output logic                   pop_valid_o,
  output rdwe_pkg::frame_t       pop_frame_o,
  input  wire logic              pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rdwe_pkg::frame_t mem_q [Depth];
  logic [PtrW-1:0]  wptr_d, wptr_q, rptr_d, rptr_q;
  logic [CntW-1:0]  cnt_d, cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != FullCnt;
  assign pop_valid_o  = cnt_q != '0;
  assign pop_frame_o  = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_frame_i;
    end
  end

endmodule

`default_nettype wire

@@ design/rdwe_back.sv @@
`default_nettype none

module rdwe_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rdwe_pkg::cfg_t    cfg_i,
  input  wire logic              frame_valid_i,
  input  wire rdwe_pkg::frame_t  frame_i,
  output logic                   frame_ready_o,
  rdwe_sym_if.source             sym_o
);

  localparam logic [rdwe_pkg::SymIdxW-1:0] ProgIdx =
    rdwe_pkg::SymIdxW'(rdwe_pkg::FrameW);

  logic                           busy_d, busy_q;
  logic [rdwe_pkg::SymIdxW-1:0]   idx_d, idx_q;
  rdwe_pkg::frame_t               shift_d, shift_q;
  logic                           out_valid_d, out_valid_q;
  logic [rdwe_pkg::GapW-1:0]      off_d, off_q;
  logic [rdwe_pkg::OnW-1:0]       on_d, on_q;
  logic                           bit_d, bit_q;
  logic                           prog_d, prog_q;
  logic                           last_d, last_q;
  logic                           advance, final_sym, load, cur_bit;

  assign advance       = busy_q && (!out_valid_q || sym_o.ready);
  assign final_sym     = idx_q == ProgIdx;
  assign frame_ready_o = !busy_q || (advance && final_sym);
  assign load          = frame_valid_i && frame_ready_o;
  assign cur_bit       = shift_q[rdwe_pkg::FrameW-1];

  assign sym_o.valid        = out_valid_q;
  assign sym_o.off_cycles   = off_q;
  assign sym_o.on_cycles    = on_q;
  assign sym_o.symbol_bit   = bit_q;
  assign sym_o.program_wait = prog_q;
  assign sym_o.last         = last_q;

  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    shift_d     = shift_q;
    out_valid_d = out_valid_q && !sym_o.ready;
    off_d       = off_q;
    on_d        = on_q;
    bit_d       = bit_q;
    prog_d      = prog_q;
    last_d      = last_q;
    if (advance) begin
      out_valid_d = 1'b1;
      if (final_sym) begin
        off_d  = cfg_i.bit_gap;
        on_d   = cfg_i.program_on;
        bit_d  = 1'b0;
        prog_d = 1'b1;
        last_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        off_d   = (idx_q == '0) ? cfg_i.start_gap : cfg_i.bit_gap;
        on_d    = rdwe_pkg::OnW'(cur_bit ? cfg_i.one_on : cfg_i.zero_on);
        bit_d   = cur_bit;
        prog_d  = 1'b0;
        last_d  = 1'b0;
        idx_d   = idx_q + 1'b1;
        shift_d = {shift_q[rdwe_pkg::FrameW-2:0], 1'b0};
      end
    end
    if (load) begin
      busy_d  = 1'b1;
      idx_d   = '0;
      shift_d = frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    off_q   <= off_d;
    on_q    <= on_d;
    bit_q   <= bit_d;
    prog_q  <= prog_d;
    last_q  <= last_d;
  end

endmodule

`default_nettype wire

@@ design/rfid_downlink_write_encoder_unit.sv @@
`default_nettype none

// A command passes through the front-end register, the queue and the back end's shift
// and symbol output registers. The back-end serialiser sends one symbol per cycle while
// the sink is ready, 39 per command; the front end and queue take later commands meanwhile.
// Reset: the timing registers return to their default values and the queue empties.

module rfid_downlink_write_encoder_unit #(
  parameter int unsigned QueueDepth = rdwe_pkg::DefaultQueueDepth
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rdwe_cmd_if.sink    cmd_i,
  rdwe_sym_if.source  sym_o,
  rdwe_cfg_if.sink    cfg_i
);

  rdwe_pkg::cfg_t   cfg;
  logic             push_valid, push_ready;
  rdwe_pkg::frame_t push_frame;
  logic             pop_valid, pop_ready;
  rdwe_pkg::frame_t pop_frame;

  rdwe_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  rdwe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_frame_o (push_frame),
    .push_ready_i (push_ready)
  );

  rdwe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_frame_i (push_frame),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_frame_o  (pop_frame),
    .pop_ready_i  (pop_ready)
  );

  rdwe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .frame_valid_i (pop_valid),
    .frame_i       (pop_frame),
    .frame_ready_o (pop_ready),
    .sym_o         (sym_o)
  );

endmodule

`default_nettype wire

@@ sim/tb_rfid_downlink_write_encoder_unit.sv @@
module tb_rfid_downlink_write_encoder_unit;
  import rdwe_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned IdlePercent   = 36;
  localparam int unsigned SettleCycles  = 8;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic               lock_bit;
    logic [DataW-1:0]   block_data;
    logic [AddrW-1:0]   block_address;
  } command_t;

  typedef struct packed {
    logic [GapW-1:0] off_cycles;
    logic [OnW-1:0]  on_cycles;
    logic            symbol_bit;
    logic            program_wait;
    logic            last;
  } symbol_t;

  class symbol_scoreboard;
    cfg_t        timing;
    symbol_t     expected_q[$];
    int unsigned errors;

    function new();
      timing.start_gap  = StartGapReset;
      timing.bit_gap    = BitGapReset;
      timing.zero_on    = ZeroOnReset;
      timing.one_on     = OneOnReset;
      timing.program_on = ProgramOnReset;
      errors            = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        REG_START_GAP:  timing.start_gap  = value[GapW-1:0];
        REG_BIT_GAP:    timing.bit_gap    = value[GapW-1:0];
        REG_ZERO_ON:    timing.zero_on    = value[BitOnW-1:0];
        REG_ONE_ON:     timing.one_on     = value[BitOnW-1:0];
        REG_PROGRAM_ON: timing.program_on = value[OnW-1:0];
        default: ;
      endcase
    endfunction

    function void note_command(command_t cmd);
      frame_t  frame;
      symbol_t sym;
      logic    b;
      frame = {cmd.opcode, cmd.lock_bit, cmd.block_data, cmd.block_address};
      for (int k = 0; k < FrameW; k++) begin
        b                = frame[FrameW-1-k];
        sym.off_cycles   = (k == 0) ? timing.start_gap : timing.bit_gap;
        sym.on_cycles    = b ? OnW'(timing.one_on) : OnW'(timing.zero_on);
        sym.symbol_bit   = b;
        sym.program_wait = 1'b0;
        sym.last         = 1'b0;
        expected_q.push_back(sym);
      end
      sym.off_cycles   = timing.bit_gap;
      sym.on_cycles    = timing.program_on;
      sym.symbol_bit   = 1'b0;
      sym.program_wait = 1'b1;
      sym.last         = 1'b1;
      expected_q.push_back(sym);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_symbol(symbol_t got);
      symbol_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected symbol %p", got));
      end else begin
        want = expected_q.pop_front();
        if (got.off_cycles !== want.off_cycles)
          report($sformatf("off_cycles %0d, expected %0d", got.off_cycles, want.off_cycles));
        if (got.on_cycles !== want.on_cycles)
          report($sformatf("on_cycles %0d, expected %0d", got.on_cycles, want.on_cycles));
        if (got.symbol_bit !== want.symbol_bit)
          report($sformatf("symbol_bit %b, expected %b", got.symbol_bit, want.symbol_bit));
        if (got.program_wait !== want.program_wait)
          report($sformatf("program_wait %b, expected %b", got.program_wait,
                           want.program_wait));
        if (got.last !== want.last)
          report($sformatf("last %b, expected %b", got.last, want.last));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   quiet_phase;
  int unsigned stalled_cycles;
  symbol_scoreboard sb;

  rdwe_cmd_if cmd_bus();
  rdwe_sym_if sym_bus();
  rdwe_cfg_if cfg_bus();

  rfid_downlink_write_encoder_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .sym_o  (sym_bus),
    .cfg_i  (cfg_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit idle_roll();
    return !quiet_phase && ($urandom_range(99) < IdlePercent);
  endfunction

  always @(negedge clk_i) begin
    sym_bus.ready = !idle_roll();
  end

  always @(posedge clk_i) begin
    if (cmd_bus.valid && cmd_bus.ready)
      sb.note_command({cmd_bus.opcode, cmd_bus.lock_bit, cmd_bus.block_data,
                       cmd_bus.block_address});
    if (cfg_bus.valid && cfg_bus.ready)
      sb.write_reg(cfg_bus.idx, cfg_bus.wdata);
    if (sym_bus.valid && sym_bus.ready)
      sb.check_symbol({sym_bus.off_cycles, sym_bus.on_cycles, sym_bus.symbol_bit,
                       sym_bus.program_wait, sym_bus.last});
  end

  always @(posedge clk_i) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
        (sym_bus.valid && sym_bus.ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= WatchdogLimit) begin
        $display("Timeout: no item moved for %0d cycles", WatchdogLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task send_command(command_t cmd);
    while (idle_roll()) begin
      cmd_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    cmd_bus.valid         = 1'b1;
    cmd_bus.opcode        = cmd.opcode;
    cmd_bus.lock_bit      = cmd.lock_bit;
    cmd_bus.block_data    = cmd.block_data;
    cmd_bus.block_address = cmd.block_address;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task send_random_commands(int unsigned count);
    command_t cmd;
    for (int i = 0; i < count; i++) begin
      cmd.opcode        = OpcodeW'($urandom_range(3));
      cmd.lock_bit      = 1'($urandom_range(1));
      cmd.block_address = AddrW'($urandom_range(7));
      case ($urandom_range(7))
        0:       cmd.block_data = '0;
        1:       cmd.block_data = '1;
        default: cmd.block_data = $urandom;
      endcase
      send_command(cmd);
    end
    cmd_bus.valid = 1'b0;
  endtask

  task write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_bus.valid = 1'b1;
    cfg_bus.idx   = idx;
    cfg_bus.wdata = value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  task apply_timing(logic [CfgDataW-1:0] start_gap, logic [CfgDataW-1:0] bit_gap,
                    logic [CfgDataW-1:0] zero_on, logic [CfgDataW-1:0] one_on,
                    logic [CfgDataW-1:0] program_on);
    write_register(REG_START_GAP, start_gap);
    write_register(REG_BIT_GAP, bit_gap);
    write_register(REG_ZERO_ON, zero_on);
    write_register(REG_ONE_ON, one_on);
    write_register(REG_PROGRAM_ON, program_on);
  endtask

  task drain_symbols();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    sb                    = new();
    quiet_phase           = 1'b0;
    stalled_cycles        = 0;
    rst_ni                = 1'b0;
    cmd_bus.valid         = 1'b0;
    cmd_bus.opcode        = '0;
    cmd_bus.lock_bit      = 1'b0;
    cmd_bus.block_data    = '0;
    cmd_bus.block_address = '0;
    sym_bus.ready         = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.idx           = '0;
    cfg_bus.wdata         = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset timing: every opcode, both lock values, every address and the data extremes.
    send_command('{2'd0, 1'b0, 32'h0000_0000, 3'd0});
    send_command('{2'd1, 1'b1, 32'hFFFF_FFFF, 3'd7});
    send_command('{2'd2, 1'b0, 32'h8000_0001, 3'd4});
    send_command('{2'd3, 1'b1, 32'h7FFF_FFFE, 3'd3});
    send_command('{2'd3, 1'b0, 32'h5555_5555, 3'd5});
    send_command('{2'd2, 1'b1, 32'hAAAA_AAAA, 3'd2});
    send_command('{2'd1, 1'b0, 32'h0000_FFFF, 3'd1});
    send_command('{2'd0, 1'b1, 32'hFFFF_0000, 3'd6});
    send_random_commands(16);
    drain_symbols();

    // Zero-length gaps and on times are passed through unchanged.
    apply_timing('0, '0, '0, '0, '0);
    send_random_commands(18);
    drain_symbols();

    // Largest values, with both sides running flat out so that the queue fills.
    apply_timing(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
    quiet_phase = 1'b1;
    send_random_commands(22);
    drain_symbols();
    quiet_phase = 1'b0;

    // Writes to the unused register indexes must leave the timing alone.
    for (int i = REG_PROGRAM_ON + 1; i < 2**CfgIdxW; i++)
      write_register(CfgIdxW'(i), CfgDataW'($urandom_range(1023)));
    send_random_commands(10);
    drain_symbols();

    for (int p = 0; p < 3; p++) begin
      apply_timing(CfgDataW'($urandom_range(1023)), CfgDataW'($urandom_range(1023)),
                   CfgDataW'($urandom_range(1023)), CfgDataW'($urandom_range(1023)),
                   CfgDataW'($urandom_range(1023)));
      send_random_commands(20);
      drain_symbols();
    end

    repeat (20) @(negedge clk_i);
    while (sb.pending() != 0) begin
      sb.report("expected symbol never arrived");
      void'(sb.expected_q.pop_front());
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
